// ----- rtl/dofa_pkg.sv -----
// ----------------------------------------------------------------------------
// dofa_pkg
// Types and codes shared by the dof numbering and assembly unit, its adder and its testbench.
// ----------------------------------------------------------------------------
package dofa_pkg;

  localparam int unsigned COMPS     = 6;
  localparam int unsigned MATS      = 3;
  localparam int unsigned IN_BITS   = 96;
  localparam int unsigned OUT_BITS  = 80;

  typedef enum logic [1:0] {
    KIND_RESTRAIN = 2'd0,
    KIND_NUMBER   = 2'd1,
    KIND_ACCUM    = 2'd2,
    KIND_READ     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_UNNUM   = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_SPARE   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IDX,
    ST_MRD,
    ST_ADD,
    ST_RD,
    ST_NUM,
    ST_CLR,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    FA_IDLE,
    FA_ALIGN,
    FA_ADD,
    FA_NORM,
    FA_ROUND
  } fa_state_e;

  localparam logic [2:0]  MATSEL_BAD = 3'd3;
  localparam logic [63:0] QNAN_DEFAULT = 64'hFFF8_0000_0000_0000;

endpackage

// ----- rtl/dofa_fadd.sv -----
// ----------------------------------------------------------------------------
// dofa_fadd
// Multi-cycle IEEE double adder, round to nearest even, one sum at a time.
// ----------------------------------------------------------------------------
module dofa_fadd (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] sum_o
);
  import dofa_pkg::*;

  fa_state_e   st_q, st_d;
  logic        sgn_q, sgn_d;
  logic        sub_q, sub_d;
  logic [11:0] e_q, e_d;
  logic [10:0] dif_q, dif_d;
  logic [56:0] ma_q, ma_d;
  logic [55:0] mb_q, mb_d;
  logic [63:0] res_q, res_d;
  logic        done_q, done_d;

  logic        a_nan, b_nan, a_inf, b_inf, swap;
  logic [63:0] x, y;
  logic [10:0] ex, ey;
  logic        hx, hy;
  logic [5:0]  sh;
  logic [55:0] shifted;
  logic        lost;
  logic [56:0] sum;
  logic [11:0] expf, e_o;
  logic        rup;
  logic [53:0] mant;
  logic [51:0] frac;

  always_comb begin
    a_nan   = (&a_i[62:52]) && (|a_i[51:0]);
    b_nan   = (&b_i[62:52]) && (|b_i[51:0]);
    a_inf   = (&a_i[62:52]) && !(|a_i[51:0]);
    b_inf   = (&b_i[62:52]) && !(|b_i[51:0]);
    swap    = b_i[62:0] > a_i[62:0];
    x       = swap ? b_i : a_i;
    y       = swap ? a_i : b_i;
    hx      = |x[62:52];
    hy      = |y[62:52];
    ex      = hx ? x[62:52] : 11'd1;
    ey      = hy ? y[62:52] : 11'd1;
    sh      = (dif_q > 11'd57) ? 6'd57 : dif_q[5:0];
    shifted = mb_q >> sh;
    lost    = (shifted << sh) != mb_q;
    sum     = sub_q ? (ma_q - {1'b0, mb_q}) : (ma_q + {1'b0, mb_q});
    expf    = ma_q[55] ? e_q : 12'd0;
    rup     = ma_q[2] & (ma_q[1] | ma_q[0] | ma_q[3]);
    mant    = {1'b0, ma_q[55:3]} + {53'd0, rup};
    if (mant[53]) begin
      e_o  = expf + 12'd1;
      frac = mant[52:1];
    end else if (expf == 12'd0 && mant[52]) begin
      e_o  = 12'd1;
      frac = mant[51:0];
    end else begin
      e_o  = expf;
      frac = mant[51:0];
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      FA_IDLE: begin
        if (start_i && !(a_nan || b_nan || a_inf || b_inf)) begin
          st_d = FA_ALIGN;
        end
      end
      FA_ALIGN: st_d = FA_ADD;
      FA_ADD: begin
        st_d = (sum == 57'd0) ? FA_IDLE : FA_NORM;
      end
      FA_NORM: begin
        if (ma_q[56] || ma_q[55] || e_q <= 12'd1) begin
          st_d = FA_ROUND;
        end
      end
      FA_ROUND: st_d = FA_IDLE;
      default:  st_d = FA_IDLE;
    endcase
  end

  always_comb begin
    sgn_d  = sgn_q;
    sub_d  = sub_q;
    e_d    = e_q;
    dif_d  = dif_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    res_d  = res_q;
    done_d = 1'b0;
    case (st_q)
      FA_IDLE: begin
        if (start_i) begin
          sgn_d = x[63];
          sub_d = x[63] ^ y[63];
          e_d   = {1'b0, ex};
          dif_d = ex - ey;
          ma_d  = {1'b0, hx, x[51:0], 3'b000};
          mb_d  = {hy, y[51:0], 3'b000};
          if (a_nan) begin
            res_d  = a_i | 64'h0008_0000_0000_0000;
            done_d = 1'b1;
          end else if (b_nan) begin
            res_d  = b_i | 64'h0008_0000_0000_0000;
            done_d = 1'b1;
          end else if (a_inf && b_inf && (a_i[63] != b_i[63])) begin
            res_d  = QNAN_DEFAULT;
            done_d = 1'b1;
          end else if (a_inf) begin
            res_d  = a_i;
            done_d = 1'b1;
          end else if (b_inf) begin
            res_d  = b_i;
            done_d = 1'b1;
          end
        end
      end
      FA_ALIGN: begin
        mb_d = shifted | {55'd0, lost};
      end
      FA_ADD: begin
        ma_d = sum;
        if (sum == 57'd0) begin
          res_d  = {sgn_q & ~sub_q, 63'd0};
          done_d = 1'b1;
        end
      end
      FA_NORM: begin
        if (ma_q[56]) begin
          ma_d = {1'b0, ma_q[56:2], ma_q[1] | ma_q[0]};
          e_d  = e_q + 12'd1;
        end else if (!ma_q[55] && e_q > 12'd1) begin
          if (ma_q[55:48] == 8'd0 && e_q > 12'd8) begin
            ma_d = ma_q << 8;
            e_d  = e_q - 12'd8;
          end else begin
            ma_d = ma_q << 1;
            e_d  = e_q - 12'd1;
          end
        end
      end
      FA_ROUND: begin
        done_d = 1'b1;
        if (e_o >= 12'd2047) begin
          res_d = {sgn_q, 11'h7FF, 52'd0};
        end else begin
          res_d = {sgn_q, e_o[10:0], frac};
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= FA_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sgn_q <= sgn_d;
    sub_q <= sub_d;
    e_q   <= e_d;
    dif_q <= dif_d;
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign sum_o  = res_q;

endmodule

// ----- rtl/dof_numbering_and_matrix_assembly_unit.sv -----
// ----------------------------------------------------------------------------
// dof_numbering_and_matrix_assembly_unit
// Restraint store, dof numbering, stiffness/mass/damping assembly and readback.
// ----------------------------------------------------------------------------
// Restraint and failed items go to the done state, which registers the result;
// a read passes the read state first. Accumulate: index read, matrix read, then
// the adder, slower where a cancellation needs a long normalising shift.
// Numbering scans the nodes in use twice, then clears the whole matrix memory.
// One item at a time; the next beat is taken once the result is registered.
// Reset clears control, counts, flags and restraints; the matrix memory is not
// cleared at reset and is unreadable until the first numbering clears it.
module dof_numbering_and_matrix_assembly_unit #(
  parameter int unsigned MAX_NODES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // node_a[2:0] comp_a[5:3] node_b[8:6] comp_b[11:9] matrix_sel[13:12]
  // entry_value[77:14] restraint_mask[83:78] row_index[89:84] col_index[95:90]
  input  logic [dofa_pkg::IN_BITS-1:0]  s_axis_tdata_i,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_value[63:0] free_dofs[69:64] total_dofs[75:70] status[77:76], zero fill
  output logic [dofa_pkg::OUT_BITS-1:0] m_axis_tdata_o
);
  import dofa_pkg::*;

  localparam int unsigned DOFS = MAX_NODES * COMPS;
  localparam int unsigned DD   = DOFS * DOFS;
  localparam int unsigned MD   = MATS * DD;
  localparam int unsigned XW   = $clog2(DOFS);
  localparam int unsigned IW   = $clog2(DOFS + 1);
  localparam int unsigned AW   = $clog2(MD);
  localparam int unsigned NW   = $clog2(MAX_NODES);
  localparam int unsigned CW   = 8;

  // input fields
  kind_e       in_kind;
  logic [2:0]  in_na, in_ca, in_nb, in_cb;
  logic [1:0]  in_sel;
  logic [63:0] in_val;
  logic [5:0]  in_mask, in_row, in_col;

  assign in_kind = kind_e'(s_axis_tuser_i);
  assign in_na   = s_axis_tdata_i[2:0];
  assign in_ca   = s_axis_tdata_i[5:3];
  assign in_nb   = s_axis_tdata_i[8:6];
  assign in_cb   = s_axis_tdata_i[11:9];
  assign in_sel  = s_axis_tdata_i[13:12];
  assign in_val  = s_axis_tdata_i[77:14];
  assign in_mask = s_axis_tdata_i[83:78];
  assign in_row  = s_axis_tdata_i[89:84];
  assign in_col  = s_axis_tdata_i[95:90];

  state_e      st_q, st_d;
  logic [3:0]  ncnt_q;
  logic        numbered_q, numbered_d;
  logic [IW-1:0] free_q, free_d, total_q, total_d, next_q, next_d;
  logic [5:0]  rstr_q [MAX_NODES];
  logic        pass_q, pass_d;
  logic [NW-1:0] nd_q, nd_d;
  logic [2:0]  c_q, c_d;
  logic [AW-1:0] clr_q, clr_d, maddr_q, maddr_d;
  logic [1:0]  sel_q, sel_d;
  logic [63:0] val_q, val_d;
  logic [63:0] rv_q, rv_d;
  status_e     stat_q, stat_d;
  logic        ov_q, ov_d;
  logic [OUT_BITS-1:0] otd_q, otd_d;

  logic [XW-1:0] idx_mem [DOFS];
  logic [XW-1:0] ia_q, ib_q;
  logic          iwe, ire;
  logic [XW-1:0] iwa, iwd, ira, irb;

  logic [63:0]   mat_mem [MD];
  logic [63:0]   mat_rd_q;
  logic          mwe, mre;
  logic [AW-1:0] mwa, mra;
  logic [63:0]   mwd;

  logic          fa_start, fa_done;
  logic [63:0]   fa_sum;

  logic [CW-1:0] nuse;
  status_e       chk;
  logic          accept, held, last_c, last_n, rstr_we;
  logic [AW-1:0] acc_addr, rd_addr;

  assign accept          = s_axis_tvalid_i && (st_q == ST_IDLE);
  assign s_axis_tready_o = (st_q == ST_IDLE);

  always_comb begin
    if (ncnt_q == 4'd0) begin
      nuse = CW'(1);
    end else if (CW'(ncnt_q) > CW'(MAX_NODES)) begin
      nuse = CW'(MAX_NODES);
    end else begin
      nuse = CW'(ncnt_q);
    end
  end

  always_comb begin
    chk = STAT_OK;
    case (in_kind)
      KIND_RESTRAIN: begin
        if (CW'(in_na) >= nuse) chk = STAT_RANGE;
      end
      KIND_NUMBER: chk = STAT_OK;
      KIND_ACCUM: begin
        if (!numbered_q) begin
          chk = STAT_UNNUM;
        end else if (CW'(in_na) >= nuse || CW'(in_nb) >= nuse || in_ca >= 3'(COMPS) ||
                     in_cb >= 3'(COMPS) || {1'b0, in_sel} == MATSEL_BAD) begin
          chk = STAT_RANGE;
        end
      end
      KIND_READ: begin
        if (!numbered_q) begin
          chk = STAT_UNNUM;
        end else if (8'(in_row) >= 8'(total_q) || 8'(in_col) >= 8'(total_q) ||
                     {1'b0, in_sel} == MATSEL_BAD || 8'(in_row) >= 8'(DOFS) ||
                     8'(in_col) >= 8'(DOFS)) begin
          chk = STAT_RANGE;
        end
      end
      default: chk = STAT_OK;
    endcase
  end

  assign held     = rstr_q[nd_q][c_q];
  assign last_c   = (c_q == 3'(COMPS - 1));
  assign last_n   = (CW'(nd_q) == nuse - CW'(1));
  assign acc_addr = AW'(sel_q) * AW'(DD) + AW'(ia_q) * AW'(DOFS) + AW'(ib_q);
  assign rd_addr  = AW'(in_sel) * AW'(DD) + AW'(in_row) * AW'(DOFS) + AW'(in_col);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_NUMBER) begin
            st_d = ST_NUM;
          end else if (chk == STAT_OK && in_kind == KIND_ACCUM) begin
            st_d = ST_IDX;
          end else if (chk == STAT_OK && in_kind == KIND_READ) begin
            st_d = ST_RD;
          end else begin
            st_d = ST_DONE;
          end
        end
      end
      ST_IDX:  st_d = ST_MRD;
      ST_MRD:  st_d = ST_ADD;
      ST_ADD:  st_d = fa_done ? ST_DONE : ST_ADD;
      ST_RD:   st_d = ST_DONE;
      ST_NUM:  st_d = (last_c && last_n && pass_q) ? ST_CLR : ST_NUM;
      ST_CLR:  st_d = (clr_q == AW'(MD - 1)) ? ST_DONE : ST_CLR;
      ST_DONE: st_d = (!ov_q || m_axis_tready_i) ? ST_IDLE : ST_DONE;
      default: st_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    numbered_d = numbered_q;
    free_d     = free_q;
    total_d    = total_q;
    next_d     = next_q;
    pass_d     = pass_q;
    nd_d       = nd_q;
    c_d        = c_q;
    clr_d      = clr_q;
    maddr_d    = maddr_q;
    sel_d      = sel_q;
    val_d      = val_q;
    rv_d       = rv_q;
    stat_d     = stat_q;
    ov_d       = ov_q && !m_axis_tready_i;
    otd_d      = otd_q;
    rstr_we    = 1'b0;
    iwe        = 1'b0;
    iwa        = XW'(CW'(nd_q) * CW'(COMPS) + CW'(c_q));
    iwd        = XW'(next_q);
    ire        = 1'b0;
    ira        = XW'(CW'(in_na) * CW'(COMPS) + CW'(in_ca));
    irb        = XW'(CW'(in_nb) * CW'(COMPS) + CW'(in_cb));
    mre        = 1'b0;
    mra        = rd_addr;
    mwe        = 1'b0;
    mwa        = clr_q;
    mwd        = 64'd0;
    fa_start   = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          sel_d  = in_sel;
          val_d  = in_val;
          rv_d   = 64'd0;
          stat_d = chk;
          pass_d = 1'b0;
          nd_d   = '0;
          c_d    = 3'd0;
          next_d = '0;
          if (in_kind == KIND_RESTRAIN && chk == STAT_OK) begin
            rstr_we    = 1'b1;
            numbered_d = 1'b0;
          end
          if (in_kind == KIND_ACCUM && chk == STAT_OK) ire = 1'b1;
          if (in_kind == KIND_READ && chk == STAT_OK) mre = 1'b1;
        end
      end
      ST_IDX: begin
        mre     = 1'b1;
        mra     = acc_addr;
        maddr_d = acc_addr;
      end
      ST_MRD: begin
        fa_start = 1'b1;
      end
      ST_ADD: begin
        if (fa_done) begin
          mwe = 1'b1;
          mwa = maddr_q;
          mwd = fa_sum;
        end
      end
      ST_RD: begin
        rv_d = mat_rd_q;
      end
      ST_NUM: begin
        iwe    = (held == pass_q);
        next_d = next_q + IW'(iwe);
        if (last_c) begin
          c_d = 3'd0;
          if (last_n) begin
            nd_d = '0;
            if (!pass_q) begin
              free_d = next_d;
              pass_d = 1'b1;
            end else begin
              total_d = next_d;
              clr_d   = '0;
            end
          end else begin
            nd_d = nd_q + NW'(1);
          end
        end else begin
          c_d = c_q + 3'd1;
        end
      end
      ST_CLR: begin
        mwe   = 1'b1;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(MD - 1)) numbered_d = 1'b1;
      end
      ST_DONE: begin
        if (!ov_q || m_axis_tready_i) begin
          ov_d  = 1'b1;
          otd_d = {2'b00, stat_q, 6'(total_q), 6'(free_q), rv_q};
        end
      end
      default: begin
        ov_d = ov_q;
      end
    endcase
    if (cfg_we_i) numbered_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      ncnt_q     <= 4'd8;
      numbered_q <= 1'b0;
      free_q     <= '0;
      total_q    <= '0;
      ov_q       <= 1'b0;
      next_q     <= '0;
      pass_q     <= 1'b0;
      nd_q       <= '0;
      c_q        <= 3'd0;
      clr_q      <= '0;
      for (int i = 0; i < int'(MAX_NODES); i++) rstr_q[i] <= 6'd0;
    end else begin
      st_q       <= st_d;
      numbered_q <= numbered_d;
      free_q     <= free_d;
      total_q    <= total_d;
      ov_q       <= ov_d;
      next_q     <= next_d;
      pass_q     <= pass_d;
      nd_q       <= nd_d;
      c_q        <= c_d;
      clr_q      <= clr_d;
      if (cfg_we_i) ncnt_q <= cfg_wdata_i;
      if (rstr_we) rstr_q[NW'(in_na)] <= rstr_q[NW'(in_na)] | in_mask;
    end
  end

  always_ff @(posedge clk_i) begin
    maddr_q <= maddr_d;
    sel_q   <= sel_d;
    val_q   <= val_d;
    rv_q    <= rv_d;
    stat_q  <= stat_d;
    otd_q   <= otd_d;
  end

  always_ff @(posedge clk_i) begin
    if (iwe) idx_mem[iwa] <= iwd;
    if (ire) begin
      ia_q <= idx_mem[ira];
      ib_q <= idx_mem[irb];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mwe) mat_mem[mwa] <= mwd;
    if (mre) mat_rd_q <= mat_mem[mra];
  end

  dofa_fadd u_fadd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fa_start),
    .a_i     (mat_rd_q),
    .b_i     (val_q),
    .done_o  (fa_done),
    .sum_o   (fa_sum)
  );

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = otd_q;

endmodule

// ----- tb/tb_dof_numbering_and_matrix_assembly_unit.sv -----
// ----------------------------------------------------------------------------
// tb_dof_numbering_and_matrix_assembly_unit
// Checks restraint masks, dof numbering and stiffness, mass and damping
// assembly. A predictor with its own restraint store, index table and matrix
// store works out the result of each accepted beat. Results are checked in
// order and field by field, with random idling on both streams in most phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dof_numbering_and_matrix_assembly_unit;
  import dofa_pkg::*;

  localparam int unsigned NODES = 8;
  localparam int unsigned DOFS  = NODES * COMPS;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  node_a;
    logic [2:0]  comp_a;
    logic [2:0]  node_b;
    logic [2:0]  comp_b;
    logic [1:0]  matrix_sel;
    logic [63:0] entry_value;
    logic [5:0]  restraint_mask;
    logic [5:0]  row_index;
    logic [5:0]  col_index;
  } asm_item_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  total_dofs;
    logic [5:0]  free_dofs;
    logic [63:0] read_value;
  } asm_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [3:0]          cfg_wdata_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [IN_BITS-1:0]  s_axis_tdata_i = '0;
  logic [1:0]          s_axis_tuser_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OUT_BITS-1:0] m_axis_tdata_o;

  dof_numbering_and_matrix_assembly_unit #(.MAX_NODES(NODES)) dut (.*);

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [5:0]  restraint_mask_q[NODES];
  logic [5:0]  dof_index_q[DOFS];
  logic [63:0] global_matrix[int];
  logic [3:0]  node_count_q = 4'd8;
  logic [5:0]  free_cnt_q = '0;
  logic [5:0]  total_cnt_q = '0;
  bit          numbered_q = 1'b0;

  asm_item_t   beats_to_send[$];
  asm_result_t results_due[$];
  asm_item_t   beat_on_bus;
  int          send_idle_pct = 26;
  int          recv_idle_pct = 61;
  int          mismatches = 0;

  function automatic int unsigned nodes_used();
    if (node_count_q == 0) return 1;
    if (node_count_q > NODES) return NODES;
    return node_count_q;
  endfunction

  function automatic bit is_nan(logic [63:0] b);
    return b[62:52] == 11'h7FF && b[51:0] != 0;
  endfunction

  task automatic number_dofs();
    int unsigned next;
    next = 0;
    for (int p = 0; p < 2; p++) begin
      for (int nd = 0; nd < nodes_used(); nd++)
        for (int c = 0; c < COMPS; c++)
          if (restraint_mask_q[nd][c] == p[0]) begin
            dof_index_q[nd*COMPS+c] = next[5:0];
            next++;
          end
      if (p == 0) free_cnt_q = next[5:0];
    end
    total_cnt_q = next[5:0];
    global_matrix.delete();
    numbered_q = 1'b1;
  endtask

  task automatic assemble(input asm_item_t it, output asm_result_t r);
    int unsigned n, key;
    logic [5:0]  ri, ci;
    logic [63:0] old;
    n = nodes_used();
    r = '0;
    r.status = STAT_OK;
    case (it.kind)
      KIND_RESTRAIN: begin
        if (it.node_a >= n) r.status = STAT_RANGE;
        else begin
          restraint_mask_q[it.node_a] |= it.restraint_mask;
          numbered_q = 1'b0;
        end
      end
      KIND_NUMBER: number_dofs();
      KIND_ACCUM: begin
        if (!numbered_q) r.status = STAT_UNNUM;
        else if (it.node_a >= n || it.node_b >= n || it.comp_a >= COMPS ||
                 it.comp_b >= COMPS || it.matrix_sel >= MATS) r.status = STAT_RANGE;
        else begin
          ri = dof_index_q[it.node_a*COMPS+it.comp_a];
          ci = dof_index_q[it.node_b*COMPS+it.comp_b];
          key = it.matrix_sel*DOFS*DOFS + ri*DOFS + ci;
          old = global_matrix.exists(key) ? global_matrix[key] : 64'd0;
          global_matrix[key] = $realtobits($bitstoreal(old) +
                                           $bitstoreal(it.entry_value));
        end
      end
      default: begin
        if (!numbered_q) r.status = STAT_UNNUM;
        else if (it.row_index >= total_cnt_q || it.col_index >= total_cnt_q ||
                 it.matrix_sel >= MATS) r.status = STAT_RANGE;
        else begin
          key = it.matrix_sel*DOFS*DOFS + it.row_index*DOFS + it.col_index;
          r.read_value = global_matrix.exists(key) ? global_matrix[key] : 64'd0;
        end
      end
    endcase
    r.free_dofs  = free_cnt_q;
    r.total_dofs = total_cnt_q;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    asm_result_t r;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        assemble(beat_on_bus, r);
        results_due = {results_due, r};
        void'(beats_to_send.pop_front());
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (beats_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          beat_on_bus     <= beats_to_send[0];
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= beats_to_send[0].kind;
          s_axis_tdata_i  <= {beats_to_send[0].col_index, beats_to_send[0].row_index,
                              beats_to_send[0].restraint_mask, beats_to_send[0].entry_value,
                              beats_to_send[0].matrix_sel, beats_to_send[0].comp_b,
                              beats_to_send[0].node_b, beats_to_send[0].comp_a,
                              beats_to_send[0].node_a};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    asm_result_t got, want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o[77:0];
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", got);
        end else begin
          want = results_due.pop_front();
          if (got.free_dofs != want.free_dofs || got.total_dofs != want.total_dofs ||
              got.status != want.status || m_axis_tdata_o[79:78] != 2'b00 ||
              (got.read_value != want.read_value &&
               !(is_nan(got.read_value) && is_nan(want.read_value)))) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected val %h free %0d total %0d st %0d, ",
                        "got val %h free %0d total %0d st %0d"},
                       want.read_value, want.free_dofs, want.total_dofs, want.status,
                       got.read_value, got.free_dofs, got.total_dofs, got.status);
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [63:0] pick_double();
    case ($urandom_range(9))
      0: return {$urandom, $urandom};
      1: return 64'h7FF0_0000_0000_0000 | {1'($urandom_range(1)), 63'd0};
      2: return {$urandom_range(1) == 1, 11'h7FF, 20'h80000 | 20'($urandom), $urandom};
      3: return {$urandom_range(1) == 1, 11'd0, 20'($urandom), $urandom};
      4: return 64'h8000_0000_0000_0000;
      default: return $realtobits((real'($urandom_range(2000)) - 1000.0) / 8.0);
    endcase
  endfunction

  task automatic queue_beat(kind_e k, int na, int ca, int nb, int cb, int sel,
                            logic [63:0] v, int m, int row, int col);
    asm_item_t it;
    it = '{k, na[2:0], ca[2:0], nb[2:0], cb[2:0], sel[1:0], v, m[5:0], row[5:0], col[5:0]};
    beats_to_send = {beats_to_send, it};
  endtask

  task automatic noise_beat();
    queue_beat(kind_e'($urandom_range(3)), $urandom_range(7), $urandom_range(7),
               $urandom_range(7), $urandom_range(7), $urandom_range(3), pick_double(),
               $urandom_range(63), $urandom_range(63), $urandom_range(63));
  endtask

  task automatic assembly_run(int n);
    repeat ($urandom_range(3)) begin
      if ($urandom_range(9) == 0)
        queue_beat(KIND_RESTRAIN, $urandom_range(7), 0, 0, 0, 0, 0, $urandom_range(63), 0, 0);
      else
        queue_beat(KIND_RESTRAIN, $urandom_range(n-1), 0, 0, 0, 0, 0,
                   ($urandom_range(3) == 0) ? $urandom_range(63) : (1 << $urandom_range(5)),
                   0, 0);
    end
    queue_beat(KIND_NUMBER, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    repeat (60) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5:
          queue_beat(KIND_ACCUM, $urandom_range(n-1), $urandom_range(5),
                     $urandom_range(n-1), $urandom_range(5), $urandom_range(2),
                     pick_double(), 0, 0, 0);
        6, 7, 8:
          queue_beat(KIND_READ, 0, 0, 0, 0, $urandom_range(2), 0, 0,
                     $urandom_range(6*n-1), $urandom_range(6*n-1));
        default: noise_beat();
      endcase
    end
  endtask

  task automatic wait_idle();
    wait (beats_to_send.size() == 0 && results_due.size() == 0 && !s_axis_tvalid_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_node_count(logic [3:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    node_count_q = v;
    numbered_q   = 1'b0;
  endtask

  initial begin
    logic [3:0] counts[6];
    counts = '{4'd1, 4'd3, 4'd15, 4'd0, 4'd5, 4'd8};
    for (int i = 0; i < NODES; i++) restraint_mask_q[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: premature, extremes, range faults
    queue_beat(KIND_ACCUM, 0, 0, 0, 0, 0, 64'h3FF0_0000_0000_0000, 0, 0, 0);
    queue_beat(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_beat(KIND_RESTRAIN, 7, 0, 0, 0, 0, 0, 63, 0, 0);
    queue_beat(KIND_RESTRAIN, 0, 0, 0, 0, 0, 0, 1, 0, 0);
    queue_beat(KIND_NUMBER, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_beat(KIND_ACCUM, 7, 5, 0, 0, 2, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
    queue_beat(KIND_ACCUM, 0, 6, 0, 0, 0, 64'h3FF0_0000_0000_0000, 0, 0, 0);
    queue_beat(KIND_ACCUM, 0, 0, 0, 7, 0, 64'h3FF0_0000_0000_0000, 0, 0, 0);
    queue_beat(KIND_ACCUM, 0, 0, 0, 0, 3, 64'h3FF0_0000_0000_0000, 0, 0, 0);
    queue_beat(KIND_ACCUM, 1, 1, 1, 1, 1, 64'h7FF0_0000_0000_0000, 0, 0, 0);
    queue_beat(KIND_ACCUM, 1, 1, 1, 1, 1, 64'hFFF0_0000_0000_0000, 0, 0, 0);
    queue_beat(KIND_ACCUM, 0, 1, 0, 1, 0, 64'h8000_0000_0000_0000, 0, 0, 0);
    queue_beat(KIND_ACCUM, 0, 1, 0, 1, 0, 64'h0000_0000_0000_0001, 0, 0, 0);
    queue_beat(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_beat(KIND_READ, 0, 0, 0, 0, 3, 0, 0, 0, 0);
    queue_beat(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 47, 47);
    queue_beat(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 63, 0);
    queue_beat(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 48);
    queue_beat(KIND_RESTRAIN, 3, 0, 0, 0, 0, 0, 6, 0, 0);
    queue_beat(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph % 3 == 0) ? 26 : (ph % 3 == 1) ? 61 : 0;
      recv_idle_pct = (ph % 3 == 0) ? 61 : (ph % 3 == 1) ? 26 : 0;
      write_node_count(counts[ph]);
      repeat (2) assembly_run(nodes_used());
      repeat (8) noise_beat();
      wait_idle();
    end

    repeat (50) @(posedge clk_i);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
